// ===== hw/rtl/frht_pkg.sv =====
package frht_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;

    localparam int ROOT_W   = 32;
    localparam int KIND_W   = 8;
    localparam int ORD_W    = 32;
    localparam int SAMPLE_W = 32;
    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic OP_LOOKUP   = 1'b0;
    localparam logic OP_REMEMBER = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_EVICT  = 2'd3;

    localparam logic [SAMPLE_W-1:0] INVALID_SAMPLE_RST = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [ROOT_W-1:0] root_id;
        logic [KIND_W-1:0] kind;
        logic [ORD_W-1:0]  ordinal;
    } t_key;

endpackage

// ===== hw/rtl/fifo_replacement_hint_table.sv =====
// channel | valid      | ready       | payload
// --------+------------+-------------+---------------------------------------------
// in      | i_in_valid | o_in_ready  | i_opcode i_root_id i_kind i_ordinal i_sample
// out     | o_out_valid| i_out_ready | o_hit o_found_sample o_action o_entry_count
// cfg     | i_cfg_we   | -           | i_cfg_wdata
//
// One item per cycle while the output is not stalled; an input passes the input register, then the result register.
// Lookup and update go through the key CAM and the sample RAM in a single pass
// between the input register and the result register.
// Synchronous active-low reset clears valid bits, fill count and oldest pointer;
// no clearing pass is needed. A stalled output holds the input stage.
module fifo_replacement_hint_table #(
    parameter int TABLE_ENTRIES = frht_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [frht_pkg::ROOT_W-1:0]   i_root_id,
    input  logic [frht_pkg::KIND_W-1:0]   i_kind,
    input  logic [frht_pkg::ORD_W-1:0]    i_ordinal,
    input  logic [frht_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic [frht_pkg::SAMPLE_W-1:0] o_found_sample,
    output logic [frht_pkg::ACTION_W-1:0] o_action,
    output logic [frht_pkg::COUNT_W-1:0]  o_entry_count,
    input  logic                          i_cfg_we,
    input  logic [frht_pkg::SAMPLE_W-1:0] i_cfg_wdata
);
    import frht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic [SAMPLE_W-1:0] r_invalid_sample;

    logic                r_in_valid;
    logic                r_op;
    t_key                r_key;
    logic [SAMPLE_W-1:0] r_sample;

    logic                r_out_valid;
    logic                r_hit;
    logic [ACTION_W-1:0] r_action;
    logic [CNT_W-1:0]    r_count;

    logic                     w_advance;
    logic                     w_remember;
    logic                     w_update;
    logic                     w_insert;
    logic                     w_cam_hit;
    logic [IDX_W-1:0]         w_cam_idx;
    logic [TABLE_ENTRIES-1:0] w_match;
    logic                     w_full;
    logic [IDX_W-1:0]         w_dst;
    logic [CNT_W-1:0]         w_fill;
    logic [CNT_W-1:0]         w_fill_next;
    logic [SAMPLE_W-1:0]      w_rdata;
    logic [ACTION_W-1:0]      n_action;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    assign w_remember = (r_op == OP_REMEMBER) && (r_sample != r_invalid_sample);
    assign w_update   = w_advance && w_remember && w_cam_hit;
    assign w_insert   = w_advance && w_remember && !w_cam_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid_sample <= INVALID_SAMPLE_RST;
        end else if (i_cfg_we) begin
            r_invalid_sample <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op          <= i_opcode;
            r_key.root_id <= i_root_id;
            r_key.kind    <= i_kind;
            r_key.ordinal <= i_ordinal;
            r_sample      <= i_sample;
        end
    end

    frht_cam #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_key),
        .o_hit   (w_cam_hit),
        .o_idx   (w_cam_idx),
        .o_match (w_match),
        .i_we    (w_insert),
        .i_widx  (w_dst),
        .i_wkey  (r_key)
    );

    frht_alloc #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_alloc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_insert    (w_insert),
        .o_full      (w_full),
        .o_dst       (w_dst),
        .o_fill      (w_fill),
        .o_fill_next (w_fill_next)
    );

    frht_sram #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_sram (
        .i_clk   (i_clk),
        .i_we    (w_update || w_insert),
        .i_waddr (w_cam_hit ? w_cam_idx : w_dst),
        .i_wdata (r_sample),
        .i_re    (w_advance),
        .i_raddr (w_cam_idx),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_action = ACT_NONE;
        if (w_remember) begin
            if (w_cam_hit) begin
                n_action = ACT_UPDATE;
            end else if (w_full) begin
                n_action = ACT_EVICT;
            end else begin
                n_action = ACT_INSERT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_hit    <= (r_op == OP_LOOKUP) && w_cam_hit;
            r_action <= n_action;
            r_count  <= w_fill_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_found_sample = r_hit ? w_rdata : '0;
    assign o_action       = r_action;
    assign o_entry_count  = COUNT_W'(r_count);

    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> $onehot0(w_match))
        else $error("key present in more than one line");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_EVICT) |-> o_entry_count == COUNT_W'(TABLE_ENTRIES))
        else $error("eviction reported with table not full");

    a_hit_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> o_action == ACT_NONE)
        else $error("lookup hit reported a table change");

    a_update_keeps_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_cam_hit) |=> w_fill == $past(w_fill))
        else $error("fill count moved on a matching key");

endmodule

// ===== hw/rtl/frht_cam.sv =====
module frht_cam #(
    parameter int ENTRIES = frht_pkg::DEF_TABLE_ENTRIES,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frht_pkg::t_key     i_key,
    output logic               o_hit,
    output logic [IDX_W-1:0]   o_idx,
    output logic [ENTRIES-1:0] o_match,
    input  logic               i_we,
    input  logic [IDX_W-1:0]   i_widx,
    input  frht_pkg::t_key     i_wkey
);
    import frht_pkg::*;

    t_key               r_key [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            o_match[i] = r_valid[i] && (r_key[i] == i_key);
        end
    end

    // keys never repeat, so at most one line matches and an OR encoder will do
    always_comb begin
        o_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (o_match[i]) begin
                o_idx = o_idx | IDX_W'(i);
            end
        end
    end

    assign o_hit = |o_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_widx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key[i_widx] <= i_wkey;
        end
    end

endmodule

// ===== hw/rtl/frht_sram.sv =====
module frht_sram #(
    parameter int ENTRIES = frht_pkg::DEF_TABLE_ENTRIES,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [IDX_W-1:0]              i_waddr,
    input  logic [frht_pkg::SAMPLE_W-1:0] i_wdata,
    input  logic                          i_re,
    input  logic [IDX_W-1:0]              i_raddr,
    output logic [frht_pkg::SAMPLE_W-1:0] o_rdata
);
    import frht_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [ENTRIES];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/frht_alloc.sv =====
module frht_alloc #(
    parameter int ENTRIES = frht_pkg::DEF_TABLE_ENTRIES,
    parameter int IDX_W   = $clog2(ENTRIES),
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_insert,
    output logic             o_full,
    output logic [IDX_W-1:0] o_dst,
    output logic [CNT_W-1:0] o_fill,
    output logic [CNT_W-1:0] o_fill_next
);
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [IDX_W-1:0] r_oldest;
    logic [IDX_W-1:0] n_oldest;

    assign o_full = (r_fill == CNT_W'(ENTRIES));
    assign o_dst  = o_full ? r_oldest : r_fill[IDX_W-1:0];

    always_comb begin
        n_fill   = r_fill;
        n_oldest = r_oldest;
        if (i_insert) begin
            if (o_full) begin
                n_oldest = (r_oldest == IDX_W'(ENTRIES - 1)) ? '0 : r_oldest + 1'b1;
            end else begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_oldest <= '0;
        end else begin
            r_fill   <= n_fill;
            r_oldest <= n_oldest;
        end
    end

    assign o_fill      = r_fill;
    assign o_fill_next = n_fill;

endmodule
